/* sv/heartbeat_evidence_health_monitor_assert.svh */
// Assertion macros for the heartbeat evidence health monitor checker.
// Included by the checker file; has no other dependencies.
`ifndef HEARTBEAT_EVIDENCE_HEALTH_MONITOR_ASSERT_SVH
`define HEARTBEAT_EVIDENCE_HEALTH_MONITOR_ASSERT_SVH

// same-cycle implication
`define HEHM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heartbeat monitor check failed");

// next-cycle implication
`define HEHM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heartbeat monitor check failed");

`endif

/* sv/hehm_pkg.sv */
// Shared types and constants for the heartbeat evidence health monitor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hehm_pkg;

   localparam int AGE_BITS     = 16;
   localparam int TIMEOUT_BITS = 16;
   localparam int PERIOD_BITS  = 14;
   localparam int CMP_BITS     = (AGE_BITS > TIMEOUT_BITS) ? AGE_BITS : TIMEOUT_BITS;

   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(300);
   localparam logic [PERIOD_BITS-1:0]  PERIOD_RESET  = PERIOD_BITS'(100);
   localparam logic [31:0]             BOOT_ID_RESET = 32'd1;

   // configuration register indexes
   localparam logic [1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_PERIOD  = 2'd1;
   localparam logic [1:0] CSR_BOOT_ID = 2'd2;

   // command codes
   localparam logic CMD_STATUS = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // source state and reason codes
   localparam logic [1:0] SRC_ST_READY  = 2'd0;
   localparam logic [1:0] SRC_ST_UNAVL  = 2'd1;
   localparam logic [1:0] SRC_ST_FAULT  = 2'd2;
   localparam logic [2:0] SRC_RS_READY  = 3'd0;
   localparam logic [2:0] SRC_RS_UNAVL  = 3'd1;
   localparam logic [2:0] SRC_RS_JOINTS = 3'd3;
   localparam logic [2:0] SRC_RS_FAULT  = 3'd4;

   // health report codes
   localparam logic [1:0] HS_HEALTHY  = 2'd0;
   localparam logic [1:0] HS_DEGRADED = 2'd1;
   localparam logic [1:0] HS_FAULT    = 2'd2;
   localparam logic [2:0] HR_HEALTHY    = 3'd0;
   localparam logic [2:0] HR_SRC_FAULT  = 3'd1;
   localparam logic [2:0] HR_STALE      = 3'd2;
   localparam logic [2:0] HR_BACKWARD   = 3'd3;
   localparam logic [2:0] HR_INVALID    = 3'd4;
   localparam logic [2:0] HR_NOT_READY  = 3'd5;

   typedef enum logic [1:0] {
      CAUSE_NONE,
      CAUSE_INVALID,
      CAUSE_BACKWARD
   } cause_type;

   typedef struct packed {
      logic               command;
      logic [31:0]        message_boot_id;
      logic [31:0]        message_sequence;
      logic signed [63:0] message_stamp;
      logic               msg_ok;
      logic [1:0]         base_state;
      logic [2:0]         base_reason;
   } req_type;

   typedef struct packed {
      logic [31:0] report_sequence;
      logic [31:0] report_boot_id;
      logic        all_ready;
      logic [1:0]  health_state;
      logic [2:0]  health_reason;
   } rsp_type;

   // evidence summary as seen by a tick, age already advanced
   typedef struct packed {
      logic fresh;
      logic good;
      logic source_ready;
      logic faulted;
      logic backward;
   } evid_type;

endpackage

/* sv/hehm_evidence.sv */
// Evidence store: checks status beats, keeps accepted message and evidence age.
// Depends on hehm_pkg.
`timescale 1ns / 1ps

module hehm_evidence (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  take,
   input  hehm_pkg::req_type                     item,
   input  logic [hehm_pkg::TIMEOUT_BITS-1:0]     timeout,
   output hehm_pkg::evid_type                    status
);
   import hehm_pkg::*;

   logic                have_message_ff, have_message_in;
   logic                have_accepted_ff, have_accepted_in;
   logic                good_ff, good_in;
   logic                source_ready_ff, source_ready_in;
   logic                faulted_ff, faulted_in;
   logic [31:0]         acc_boot_ff, acc_boot_in;
   logic [31:0]         acc_seq_ff, acc_seq_in;
   logic signed [63:0]  acc_stamp_ff, acc_stamp_in;
   cause_type           cause_ff, cause_in;
   logic [AGE_BITS-1:0] age_ff, age_in;

   logic [AGE_BITS-1:0] age_plus;
   logic st_ready, st_unavl, st_fault, semantic;
   logic boot_change, id_ok, seq_ok, pass, backward, accept;

   assign age_plus = (age_ff == '1) ? age_ff : age_ff + 1'b1;

   assign st_ready = (item.base_state == SRC_ST_READY) && (item.base_reason == SRC_RS_READY);
   assign st_unavl = (item.base_state == SRC_ST_UNAVL) && (item.base_reason >= SRC_RS_UNAVL)
                     && (item.base_reason <= SRC_RS_JOINTS);
   assign st_fault = (item.base_state == SRC_ST_FAULT) && (item.base_reason == SRC_RS_FAULT);
   assign semantic = st_ready || st_unavl || st_fault;

   assign boot_change = !have_accepted_ff || (item.message_boot_id != acc_boot_ff);
   assign id_ok    = (item.message_boot_id != '0) && (item.message_sequence != '0);
   assign seq_ok   = boot_change || (item.message_sequence > acc_seq_ff);
   assign pass     = id_ok && seq_ok && item.msg_ok && semantic;
   // time order only matters inside one boot, after all other checks
   assign backward = pass && !boot_change && (item.message_stamp < acc_stamp_ff);
   assign accept   = pass && !backward;

   always_comb begin
      have_message_in  = have_message_ff;
      have_accepted_in = have_accepted_ff;
      good_in          = good_ff;
      source_ready_in  = source_ready_ff;
      faulted_in       = faulted_ff;
      acc_boot_in      = acc_boot_ff;
      acc_seq_in       = acc_seq_ff;
      acc_stamp_in     = acc_stamp_ff;
      cause_in         = cause_ff;
      age_in           = age_ff;
      if (take && (item.command == CMD_TICK)) begin
         age_in = age_plus;
      end else if (take) begin
         have_message_in  = 1'b1;
         age_in           = '0;
         good_in          = accept;
         source_ready_in  = accept && st_ready;
         faulted_in       = accept && st_fault;
         if (accept) begin
            have_accepted_in = 1'b1;
            acc_boot_in      = item.message_boot_id;
            acc_seq_in       = item.message_sequence;
            acc_stamp_in     = item.message_stamp;
            cause_in         = CAUSE_NONE;
         end else if (backward) begin
            cause_in = CAUSE_BACKWARD;
         end else begin
            cause_in = CAUSE_INVALID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_message_ff  <= 1'b0;
         have_accepted_ff <= 1'b0;
         good_ff          <= 1'b0;
         source_ready_ff  <= 1'b0;
         faulted_ff       <= 1'b0;
         acc_boot_ff      <= '0;
         acc_seq_ff       <= '0;
         acc_stamp_ff     <= '0;
         cause_ff         <= CAUSE_NONE;
         age_ff           <= '0;
      end else begin
         have_message_ff  <= have_message_in;
         have_accepted_ff <= have_accepted_in;
         good_ff          <= good_in;
         source_ready_ff  <= source_ready_in;
         faulted_ff       <= faulted_in;
         acc_boot_ff      <= acc_boot_in;
         acc_seq_ff       <= acc_seq_in;
         acc_stamp_ff     <= acc_stamp_in;
         cause_ff         <= cause_in;
         age_ff           <= age_in;
      end
   end

   // freshness against the age after this tick's increment
   always_comb begin
      status.fresh         = have_message_ff
                             && (CMP_BITS'(age_plus) <= CMP_BITS'(timeout));
      status.good          = good_ff;
      status.source_ready  = source_ready_ff;
      status.faulted       = faulted_ff;
      status.backward      = (cause_ff == CAUSE_BACKWARD);
   end

endmodule

/* sv/hehm_report.sv */
// Report period counter, health classification and result register.
// Depends on hehm_pkg.
`timescale 1ns / 1ps

module hehm_report (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic                               is_tick,
   input  logic [hehm_pkg::PERIOD_BITS-1:0]   period,
   input  logic [31:0]                        boot_id,
   input  hehm_pkg::evid_type                 status,
   input  logic                               rsp_stall,
   output logic                               take,
   output logic                               rsp_valid,
   output hehm_pkg::rsp_type                  rsp
);
   import hehm_pkg::*;

   logic [PERIOD_BITS-1:0] period_count_ff, period_count_in;
   logic [31:0]            report_count_ff, report_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [PERIOD_BITS:0] next_count;
   logic                 emit, out_free, ready, hit;
   logic [1:0]           hs;
   logic [2:0]           hr;

   assign next_count = {1'b0, period_count_ff} + 1'b1;
   // a zero period behaves as one
   assign hit      = next_count >= {1'b0, period};
   assign emit     = in_valid && is_tick && hit;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = in_valid && (!emit || out_free);

   assign ready = status.fresh && status.good && status.source_ready;

   always_comb begin
      priority if (status.fresh && status.good && status.faulted) begin
         hs = HS_FAULT;
         hr = HR_SRC_FAULT;
      end else if (!status.fresh) begin
         hs = HS_DEGRADED;
         hr = HR_STALE;
      end else if (status.backward) begin
         hs = HS_DEGRADED;
         hr = HR_BACKWARD;
      end else if (!status.good) begin
         hs = HS_DEGRADED;
         hr = HR_INVALID;
      end else if (!ready) begin
         hs = HS_DEGRADED;
         hr = HR_NOT_READY;
      end else begin
         hs = HS_HEALTHY;
         hr = HR_HEALTHY;
      end
   end

   always_comb begin
      period_count_in = period_count_ff;
      report_count_in = report_count_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_in          = rsp_ff;
      if (take && is_tick) begin
         period_count_in = hit ? '0 : next_count[PERIOD_BITS-1:0];
      end
      if (take && emit) begin
         report_count_in        = report_count_ff + 1'b1;
         rsp_valid_in           = 1'b1;
         rsp_in.report_sequence = report_count_ff + 1'b1;
         rsp_in.report_boot_id  = boot_id;
         rsp_in.all_ready       = ready;
         rsp_in.health_state    = hs;
         rsp_in.health_reason   = hr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff <= '0;
         report_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         period_count_ff <= period_count_in;
         report_count_ff <= report_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* sv/heartbeat_evidence_health_monitor.sv */
// A tick beat that closes a period is accepted into the input register; once the result
// register is free, its report is loaded there and rsp_valid rises with it.
// Throughput: one beat per cycle, sustained; a held report stalls the input only while
// the beat in line closes another period.
// Reset (synchronous, active high) clears all evidence and counters and loads the
// register defaults: timeout 300, period 100, boot id 1. No report is sent at reset.
`timescale 1ns / 1ps

module heartbeat_evidence_health_monitor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  hehm_pkg::req_type  req,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output hehm_pkg::rsp_type  rsp,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import hehm_pkg::*;

   logic [TIMEOUT_BITS-1:0] timeout_ff;
   logic [PERIOD_BITS-1:0]  period_ff;
   logic [31:0]             boot_id_ff;

   logic    in_vld_ff, in_vld_in;
   req_type in_ff;
   logic    take;
   evid_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         period_ff  <= PERIOD_RESET;
         boot_id_ff <= BOOT_ID_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIMEOUT: timeout_ff <= csr_data[TIMEOUT_BITS-1:0];
            CSR_PERIOD:  period_ff  <= csr_data[PERIOD_BITS-1:0];
            CSR_BOOT_ID: boot_id_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input register; drains whenever the stage below takes the beat
   assign req_stall = in_vld_ff && !take;
   assign in_vld_in = (req_valid && !req_stall) || (in_vld_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req;
      end
   end

   hehm_evidence u_evidence (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .item    (in_ff),
      .timeout (timeout_ff),
      .status  (status)
   );

   hehm_report u_report (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_vld_ff),
      .is_tick   (in_ff.command == CMD_TICK),
      .period    (period_ff),
      .boot_id   (boot_id_ff),
      .status    (status),
      .rsp_stall (rsp_stall),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

/* sv/hehm_checker.sv */
// Port-level checker for the heartbeat evidence health monitor, bound to the top.
// Depends on hehm_pkg and heartbeat_evidence_health_monitor_assert.svh.
`timescale 1ns / 1ps
`include "heartbeat_evidence_health_monitor_assert.svh"

module hehm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input hehm_pkg::rsp_type  rsp
);
   import hehm_pkg::*;

   logic [31:0] last_seq_ff;
   logic        seq_next, is_healthy, is_fault_state, is_fault_reason;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         last_seq_ff <= rsp.report_sequence;
      end
   end

   assign seq_next        = (rsp.report_sequence == last_seq_ff + 32'd1);
   assign is_healthy      = (rsp.health_reason == HR_HEALTHY);
   assign is_fault_state  = (rsp.health_state == HS_FAULT);
   assign is_fault_reason = (rsp.health_reason == HR_SRC_FAULT);

   // a held report stays put
   `HEHM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

   // reports are numbered consecutively from one after reset
   `HEHM_ASSERT_IMP(a_seq_step, clock, reset, rsp_valid, seq_next)

   // ready exactly when the report is healthy
   `HEHM_ASSERT_IMP(a_ready_healthy, clock, reset, rsp_valid, rsp.all_ready == is_healthy)

   // fault state goes with the source fault reason only
   `HEHM_ASSERT_IMP(a_fault_code, clock, reset, rsp_valid, is_fault_state == is_fault_reason)

   // nothing is offered right out of reset
   `HEHM_ASSERT_NXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind heartbeat_evidence_health_monitor hehm_checker u_hehm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
